### rtl/asl_pkg.sv
// shared types and constants for the sorted-insert array list
package asl_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int KIND_W   = 2;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;

    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic signed [KEY_W-1:0] key;
    } t_req;

    typedef struct packed {
        logic               ok;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] entry_count;
        logic               is_empty;
        logic               is_full;
    } t_rsp;

    typedef struct packed {
        logic                    load;
        logic [KIND_W-1:0]       kind;
        logic signed [KEY_W-1:0] key;
        logic                    full;
    } t_cell_ctl;

endpackage

### rtl/asl_cell.sv
// one list slot: holds an entry, compares it with the key and shifts to or from its neighbors
module asl_cell (
    input  logic                       i_clk,
    input  asl_pkg::t_cell_ctl         i_ctl,
    input  logic                       i_occupied,
    input  logic                       i_tail,
    input  logic [asl_pkg::KEY_W-1:0]  i_left_entry,
    input  logic [asl_pkg::KEY_W-1:0]  i_right_entry,
    input  logic                       i_left_stop,
    input  logic                       i_hit_below,
    input  logic                       i_stop_above,
    output logic [asl_pkg::KEY_W-1:0]  o_entry,
    output logic                       o_stop,
    output logic                       o_hit_ge,
    output logic                       o_stop_ge,
    output logic                       o_first_match,
    output logic                       o_ins_point
);

    logic [asl_pkg::KEY_W-1:0] r_entry;
    logic [asl_pkg::KEY_W-1:0] n_entry;
    logic                      w_match;
    logic                      w_shift_up;

    assign w_match       = i_occupied && (r_entry == i_ctl.key);
    assign o_stop        = i_occupied && !(i_ctl.key < $signed(r_entry));
    assign o_hit_ge      = i_hit_below || w_match;
    assign o_stop_ge     = i_stop_above || o_stop;
    assign o_first_match = w_match && !i_hit_below;
    assign o_ins_point   = !o_stop_ge && i_left_stop;
    assign o_entry       = r_entry;

    assign w_shift_up = !o_stop_ge && !o_ins_point && (i_occupied || i_tail);

    always_comb begin
        n_entry = r_entry;
        case (i_ctl.kind)
            asl_pkg::KIND_APPEND: begin
                if (i_tail && !i_ctl.full) begin
                    n_entry = i_ctl.key;
                end
            end
            asl_pkg::KIND_INSERT: begin
                if (!i_ctl.full) begin
                    if (o_ins_point) begin
                        n_entry = i_ctl.key;
                    end else if (w_shift_up) begin
                        n_entry = i_left_entry;
                    end
                end
            end
            asl_pkg::KIND_REMOVE: begin
                if (o_hit_ge && i_occupied) begin
                    n_entry = i_right_entry;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_entry <= n_entry;
        end
    end

endmodule

### rtl/array_list_with_sorted_insert_core.sv
// top level: row of list cells, fill count and registered response
// Takes one request per clock cycle and returns one response for each, registered in the
// cycle after the request is taken; a new request is taken while a response waits as
// long as that response leaves in the same cycle. The rate is set by the row of cells:
// every cell compares its entry with the key at once and the matching and ordering
// flags ripple through the row, so append, insert, remove and search each finish in the
// cycle of the request. Entries are undefined after reset; only the fill count and the
// response valid flag are cleared, so no clearing pass is needed.
module array_list_with_sorted_insert_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  asl_pkg::t_req  i_req,
    output logic           o_rsp_valid,
    input  logic           i_rsp_ready,
    output asl_pkg::t_rsp  o_rsp
);

    localparam int N = asl_pkg::CAPACITY;

    logic [asl_pkg::CNT_W-1:0] r_count;
    logic [asl_pkg::CNT_W-1:0] n_count;
    logic                      r_rsp_valid;
    asl_pkg::t_rsp             r_rsp;
    asl_pkg::t_rsp             n_rsp;
    asl_pkg::t_cell_ctl        w_ctl;
    logic                      w_accept;
    logic                      w_full;
    logic                      w_found;
    logic                      w_ok;
    logic [asl_pkg::POS_W-1:0] w_match_pos;
    logic [asl_pkg::POS_W-1:0] w_ins_pos;

    logic [N-1:0]                     w_occupied;
    logic [N-1:0]                     w_tail;
    logic [N-1:0]                     w_stop;
    logic [N-1:0]                     w_hit_ge;
    logic [N-1:0]                     w_stop_ge;
    logic [N-1:0]                     w_first_match;
    logic [N-1:0]                     w_ins_point;
    logic [N-1:0][asl_pkg::KEY_W-1:0] w_entry;

    assign o_req_ready = !r_rsp_valid || i_rsp_ready;
    assign w_accept    = i_req_valid && o_req_ready;
    assign w_full      = (r_count >= asl_pkg::CNT_W'(N));

    assign w_ctl.load = w_accept;
    assign w_ctl.kind = i_req.kind;
    assign w_ctl.key  = i_req.key;
    assign w_ctl.full = w_full;

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            assign w_occupied[g] = (asl_pkg::CNT_W'(g) < r_count);

            if (g == 0) begin : g_first
                assign w_tail[g] = !w_occupied[g];
            end else begin : g_rest
                assign w_tail[g] = w_occupied[g-1] && !w_occupied[g];
            end

            asl_cell u_cell (
                .i_clk         (i_clk),
                .i_ctl         (w_ctl),
                .i_occupied    (w_occupied[g]),
                .i_tail        (w_tail[g]),
                .i_left_entry  ((g == 0) ? w_entry[g] : w_entry[(g == 0) ? 0 : g-1]),
                .i_right_entry ((g == N-1) ? w_entry[g] : w_entry[(g == N-1) ? g : g+1]),
                .i_left_stop   ((g == 0) ? 1'b1 : w_stop[(g == 0) ? 0 : g-1]),
                .i_hit_below   ((g == 0) ? 1'b0 : w_hit_ge[(g == 0) ? 0 : g-1]),
                .i_stop_above  ((g == N-1) ? 1'b0 : w_stop_ge[(g == N-1) ? g : g+1]),
                .o_entry       (w_entry[g]),
                .o_stop        (w_stop[g]),
                .o_hit_ge      (w_hit_ge[g]),
                .o_stop_ge     (w_stop_ge[g]),
                .o_first_match (w_first_match[g]),
                .o_ins_point   (w_ins_point[g])
            );
        end
    endgenerate

    assign w_found = w_hit_ge[N-1];

    always_comb begin
        w_match_pos = '0;
        w_ins_pos   = '0;
        for (int i = 0; i < N; i++) begin
            if (w_first_match[i]) begin
                w_match_pos = w_match_pos | asl_pkg::POS_W'(i);
            end
            if (w_ins_point[i]) begin
                w_ins_pos = w_ins_pos | asl_pkg::POS_W'(i);
            end
        end
    end

    always_comb begin
        n_count = r_count;
        w_ok    = 1'b0;
        n_rsp   = r_rsp;
        n_rsp.position = '0;
        case (i_req.kind)
            asl_pkg::KIND_APPEND: begin
                w_ok = !w_full;
                if (w_ok) begin
                    n_count        = r_count + asl_pkg::CNT_W'(1);
                    n_rsp.position = asl_pkg::POS_W'(32'(r_count));
                end
            end
            asl_pkg::KIND_INSERT: begin
                w_ok = !w_full;
                if (w_ok) begin
                    n_count        = r_count + asl_pkg::CNT_W'(1);
                    n_rsp.position = w_ins_pos;
                end
            end
            asl_pkg::KIND_REMOVE: begin
                w_ok = w_found;
                if (w_ok) begin
                    n_count        = r_count - asl_pkg::CNT_W'(1);
                    n_rsp.position = w_match_pos;
                end
            end
            asl_pkg::KIND_SEARCH: begin
                w_ok = w_found;
                if (w_ok) begin
                    n_rsp.position = w_match_pos;
                end
            end
            default: begin
                w_ok = 1'b0;
            end
        endcase
        n_rsp.ok          = w_ok;
        n_rsp.entry_count = asl_pkg::COUNT_W'(32'(n_count));
        n_rsp.is_empty    = (n_count == '0);
        n_rsp.is_full     = (n_count >= asl_pkg::CNT_W'(N));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule
